// File: rtl/core/natua_pkg.sv
`timescale 1ns / 1ps
package natua_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int COORD_W       = 20;
  localparam int IDX_W         = 8;
  localparam int CNT_W         = 9;
  localparam int SCAN_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int ABS_W         = COORD_W + 1;
  localparam int SQ_W          = 2 * ABS_W;
  localparam int DIST_W        = SQ_W + 1;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;
  localparam int INDEX_LIMIT   = 256;
  localparam int SCAN_LIMIT    = (TABLE_ENTRIES < INDEX_LIMIT) ? TABLE_ENTRIES : INDEX_LIMIT;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } coord_t;

  typedef struct packed {
    logic             have;
    logic [IDX_W-1:0] idx;
  } best_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

// File: rtl/core/nearest_unassigned_task_allocator.sv
`timescale 1ns / 1ps
// Nearest untaken task allocator.
// Input channel (in_valid/in_stall): a beat with in_kind load writes one
// table entry (x, y, taken flag) and gives no result. A beat
// with in_kind query searches entries 0..entries_in_use-1 for the untaken
// entry nearest to (in_pos_x, in_pos_y) by squared distance, first minimum
// on a tie, returns it on the output channel and marks it taken.
// The table is a ring of cells that rotates one place per cycle past a head
// cell feeding a three-stage distance pipeline, so a query always takes a
// full turn of the ring plus a pipeline drain from accept to
// result. One item is in work at a time; in_stall is high while a query
// runs or its result beat waits.
// Output channel (out_valid/out_stall): one beat per query; the result
// register holds while out_stall is high.
// Config (APB, pready always high): entries_in_use at address 0; write only
// while idle.
// Reset (synchronous, rst_n low): taken flags and entries_in_use clear;
// coordinates stay undefined until loaded.
module nearest_unassigned_task_allocator
  import natua_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [IDX_W-1:0]          in_entry_index,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic                      in_entry_taken,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic [IDX_W-1:0]          out_nearest_index,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  state_t            state_r, state_nxt;
  logic [SCAN_W-1:0] k_r, k_nxt;
  logic [1:0]        drain_r, drain_nxt;
  logic [CNT_W-1:0]  in_use_r;
  coord_t            target_r;
  logic              out_valid_r;
  logic              out_found_r;
  logic [IDX_W-1:0]  out_idx_r;

  logic              accept, query_go, shift_en, done, issue_vld;
  logic [SCAN_W-1:0] scan_cnt;
  best_t             best;
  coord_t            in_pos;
  coord_t            cell_pos   [TABLE_ENTRIES];
  logic              cell_taken [TABLE_ENTRIES];

  assign pready   = 1'b1;
  assign prdata   = DATA_W'(in_use_r);
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;
  assign query_go = accept && (in_kind == KIND_QUERY);
  assign in_pos.x = in_pos_x;
  assign in_pos.y = in_pos_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ENTRIES_IN_USE)) begin
      in_use_r <= pwdata[CNT_W-1:0];
    end
  end

  // clamp scan length to the table and to the index range
  always_comb begin
    if (32'(in_use_r) > SCAN_LIMIT) begin
      scan_cnt = SCAN_W'(SCAN_LIMIT);
    end else begin
      scan_cnt = SCAN_W'(in_use_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    drain_nxt = drain_r;
    shift_en  = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        if (query_go) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift_en = 1'b1;
        k_nxt    = k_r + 1'b1;
        if (k_r == SCAN_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = ST_DRAIN;
          drain_nxt = '0;
        end
      end
      ST_DRAIN: begin
        // wait out the distance pipeline
        drain_nxt = drain_r + 1'b1;
        if (drain_r == 2'd2) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        done      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (query_go) begin
      target_r <= in_pos;
    end
  end

  // ring of cells; cell 0 is the head
  genvar gi;
  generate
    for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
      localparam int NXT = (gi + 1) % TABLE_ENTRIES;
      logic ld, st;
      assign ld = accept && (in_kind == KIND_LOAD) && (32'(in_entry_index) == gi);
      assign st = done && best.have && (32'(best.idx) == gi);
      natua_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (ld),
        .load_pos  (in_pos),
        .load_taken(in_entry_taken),
        .shift_en  (shift_en),
        .prev_pos  (cell_pos[NXT]),
        .prev_taken(cell_taken[NXT]),
        .set_taken (st),
        .pos       (cell_pos[gi]),
        .taken     (cell_taken[gi])
      );
    end
  endgenerate

  assign issue_vld = shift_en && (k_r < scan_cnt) && !cell_taken[0];

  natua_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (query_go),
    .issue_vld(issue_vld),
    .issue_idx(k_r[IDX_W-1:0]),
    .target   (target_r),
    .head     (cell_pos[0]),
    .best     (best)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_found_r <= best.have;
      out_idx_r   <= best.idx;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_nearest_index = out_idx_r;

  // a result beat only appears right after a finished scan
  a_done_before_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result beat without finished scan");

  // no beat accepted while a query is in flight
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !accept)
    else $error("input accepted during scan");

  // not found reports index zero
  a_nf_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_idx_r == '0))
    else $error("index nonzero without a find");

  // ring is back in place when the scan ends
  a_full_turn: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && state_nxt == ST_DRAIN) |-> k_r == SCAN_W'(TABLE_ENTRIES - 1))
    else $error("scan ended off alignment");

endmodule

// File: rtl/core/natua_cell.sv
`timescale 1ns / 1ps
module natua_cell
  import natua_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load_en,
  input  coord_t load_pos,
  input  logic   load_taken,
  input  logic   shift_en,
  input  coord_t prev_pos,
  input  logic   prev_taken,
  input  logic   set_taken,
  output coord_t pos,
  output logic   taken
);

  coord_t pos_r;
  logic   taken_r;

  // coordinates carry no reset
  always_ff @(posedge clk) begin
    if (load_en) begin
      pos_r <= load_pos;
    end else if (shift_en) begin
      pos_r <= prev_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= 1'b0;
    end else if (load_en) begin
      taken_r <= load_taken;
    end else if (shift_en) begin
      taken_r <= prev_taken;
    end else if (set_taken) begin
      taken_r <= 1'b1;
    end
  end

  assign pos   = pos_r;
  assign taken = taken_r;

endmodule

// File: rtl/core/natua_dist.sv
`timescale 1ns / 1ps
module natua_dist
  import natua_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             issue_vld,
  input  logic [IDX_W-1:0] issue_idx,
  input  coord_t           target,
  input  coord_t           head,
  output best_t            best
);

  logic                    a_vld_r;
  logic [IDX_W-1:0]        a_idx_r;
  logic [ABS_W-1:0]        a_dx_r, a_dy_r;
  logic                    b_vld_r;
  logic [IDX_W-1:0]        b_idx_r;
  logic [SQ_W-1:0]         b_sx_r, b_sy_r;
  logic                    have_r;
  logic [IDX_W-1:0]        best_idx_r;
  logic [DIST_W-1:0]       best_d_r;

  logic signed [ABS_W-1:0] dx, dy;
  logic [ABS_W-1:0]        adx, ady;
  logic [DIST_W-1:0]       sum;

  always_comb begin
    dx  = ABS_W'(head.x) - ABS_W'(target.x);
    dy  = ABS_W'(head.y) - ABS_W'(target.y);
    adx = dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
    ady = dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
    sum = DIST_W'(b_sx_r) + DIST_W'(b_sy_r);
  end

  always_ff @(posedge clk) begin
    a_idx_r <= issue_idx;
    a_dx_r  <= adx;
    a_dy_r  <= ady;
    b_idx_r <= a_idx_r;
    b_sx_r  <= a_dx_r * a_dx_r;
    b_sy_r  <= a_dy_r * a_dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      a_vld_r <= issue_vld;
      b_vld_r <= a_vld_r;
      // first strict minimum wins
      if (b_vld_r && (!have_r || sum < best_d_r)) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld_r && (!have_r || sum < best_d_r)) begin
      best_idx_r <= b_idx_r;
      best_d_r   <= sum;
    end
  end

  assign best.have = have_r;
  assign best.idx  = have_r ? best_idx_r : '0;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import natua_pkg::*;

  // Cycle budget: each query takes a full turn of the ring, and the result can
  // wait out long receiver stalls. This limit is several times the slowest run.
  localparam int CYCLE_LIMIT = 3000000;
  // Let a query finish, with margin, before touching config.
  localparam int DRAIN_CYCLES = TABLE_ENTRIES + 16;
  localparam int HOLD_CYCLES  = 900;
  localparam logic [ADDR_W-1:0] ENTRIES_ADDR = ADDR_W'(4 * REG_ENTRIES_IN_USE);
  // Address of the slot after the only register; writes there must be ignored.
  localparam logic [ADDR_W-1:0] UNUSED_ADDR  = ADDR_W'(4);
  localparam int CMAX = 524287;
  localparam int CMIN = -524288;

  typedef struct {
    logic             found;
    logic [IDX_W-1:0] idx;
  } pick_t;

  typedef struct {
    int               cfg;      // value written before the beat, -1 for none
    logic             kind;
    int               idx;
    int               x;
    int               y;
    logic             taken;
    bit               literal;  // expected result typed in below
    logic             lit_found;
    int               lit_idx;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = KIND_LOAD;
  logic [IDX_W-1:0] in_entry_index = '0;
  logic signed [COORD_W-1:0] in_pos_x = '0;
  logic signed [COORD_W-1:0] in_pos_y = '0;
  logic in_entry_taken = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_found;
  logic [IDX_W-1:0] out_nearest_index;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // Shadow copy of the task table and register.
  logic signed [COORD_W-1:0] task_x [TABLE_ENTRIES];
  logic signed [COORD_W-1:0] task_y [TABLE_ENTRIES];
  logic                      task_claimed [TABLE_ENTRIES];
  logic [CNT_W-1:0]          tasks_in_use;

  pick_t picks_due[$];
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    hold_now = 1'b0;
  bit    hold_go = 1'b0;
  int    errors = 0;
  int    cycles = 0;
  int    n_loads = 0, n_queries = 0, n_found = 0, n_checked = 0;

  nearest_unassigned_task_allocator i_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_kind, .in_entry_index, .in_pos_x, .in_pos_y,
    .in_entry_taken,
    .out_valid, .out_stall, .out_found, .out_nearest_index,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing beats.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_now <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_now <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_now || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker: values sampled at the edge are the pre-edge values.
  always @(posedge clk) begin
    pick_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (picks_due.size() == 0) begin
        $error("result beat with nothing expected: found=%0b idx=%0d",
               out_found, out_nearest_index);
        errors++;
      end else begin
        want = picks_due.pop_front();
        n_checked++;
        if (out_found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_found);
          errors++;
        end
        if (out_nearest_index !== want.idx) begin
          $error("nearest_index: expected %0d, got %0d", want.idx, out_nearest_index);
          errors++;
        end
      end
    end
  end

  // Nearest untaken task search, first strict minimum wins; claims the winner.
  function automatic pick_t claim_nearest(logic signed [COORD_W-1:0] qx,
                                          logic signed [COORD_W-1:0] qy);
    pick_t res;
    int span;
    longint unsigned d, best_d;
    longint dx, dy;
    res.found = 1'b0;
    res.idx = '0;
    best_d = 0;
    span = tasks_in_use;
    if (span > SCAN_LIMIT) span = SCAN_LIMIT;
    for (int i = 0; i < span; i++) begin
      if (!task_claimed[i]) begin
        dx = longint'(qx) - longint'(task_x[i]);
        dy = longint'(qy) - longint'(task_y[i]);
        d = longint'(dx * dx) + longint'(dy * dy);
        if (!res.found || d < best_d) begin
          res.found = 1'b1;
          res.idx = IDX_W'(i);
          best_d = d;
        end
      end
    end
    if (res.found) task_claimed[res.idx] = 1'b1;
    return res;
  endfunction

  task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ENTRIES_ADDR) tasks_in_use = data[CNT_W-1:0];
  endtask

  // Reconfigure only once the block has drained.
  task automatic set_in_use(int n);
    wait (picks_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write(ENTRIES_ADDR, DATA_W'(n));
  endtask

  // Offer one beat and return after the edge that accepted it.
  task automatic send_beat(logic kind, int idx, int x, int y, logic taken,
                           bit literal = 0, logic lit_found = 0, int lit_idx = 0);
    bit ok;
    pick_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_entry_index <= IDX_W'(idx);
    in_pos_x <= COORD_W'(x);
    in_pos_y <= COORD_W'(y);
    in_entry_taken <= taken;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    if (kind == KIND_LOAD) begin
      n_loads++;
      task_x[idx] = COORD_W'(x);
      task_y[idx] = COORD_W'(y);
      task_claimed[idx] = taken;
    end else begin
      n_queries++;
      p = claim_nearest(COORD_W'(x), COORD_W'(y));
      if (p.found) n_found++;
      if (literal) begin
        p.found = lit_found;
        p.idx = IDX_W'(lit_idx);
      end
      picks_due = {picks_due, p};
    end
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return ($urandom_range(1)) ? CMAX : CMIN;
      1: return $urandom_range(16) - 8;  // dense cluster, many ties
      default: return $urandom_range(CMAX - CMIN) + CMIN;
    endcase
  endfunction

  task automatic random_beat();
    if ($urandom_range(99) < 45) begin
      send_beat(KIND_QUERY, $urandom_range(255), rand_coord(), rand_coord(),
                $urandom_range(1));
    end else begin
      send_beat(KIND_LOAD, $urandom_range(255), rand_coord(), rand_coord(),
                ($urandom_range(99) < 20));
    end
  endtask

  row_t dir_rows[$];

  initial begin
    // Directed: empty table, extremes, taken entries, ties, ignored fields.
    dir_rows = '{
      '{0,  KIND_QUERY, 0,   0,    0,    1'b0, 1, 1'b0, 0},
      '{-1, KIND_LOAD,  0,   CMIN, CMIN, 1'b0, 0, 1'b0, 0},
      '{-1, KIND_LOAD,  1,   CMAX, CMAX, 1'b0, 0, 1'b0, 0},
      '{-1, KIND_LOAD,  2,   0,    0,    1'b1, 0, 1'b0, 0},
      '{-1, KIND_LOAD,  3,   0,    0,    1'b0, 0, 1'b0, 0},
      '{-1, KIND_LOAD,  4,   0,    0,    1'b0, 0, 1'b0, 0},
      '{-1, KIND_LOAD,  255, 100,  -100, 1'b0, 0, 1'b0, 0},
      '{5,  KIND_QUERY, 0,   1,    1,    1'b0, 0, 1'b0, 0},
      '{-1, KIND_QUERY, 255, 1,    1,    1'b1, 0, 1'b0, 0},
      '{-1, KIND_QUERY, 0,   CMAX, CMAX, 1'b0, 0, 1'b0, 0},
      '{-1, KIND_QUERY, 0,   CMIN, CMIN, 1'b0, 0, 1'b0, 0},
      '{-1, KIND_QUERY, 0,   CMIN, CMAX, 1'b0, 1, 1'b0, 0},
      '{-1, KIND_LOAD,  3,   CMAX, CMIN, 1'b0, 0, 1'b0, 0},
      '{-1, KIND_QUERY, 0,   0,    0,    1'b0, 1, 1'b1, 3},
      '{1,  KIND_LOAD,  0,   5,    5,    1'b0, 0, 1'b0, 0},
      '{-1, KIND_QUERY, 0,   CMAX, CMIN, 1'b0, 1, 1'b1, 0}
    };
    for (int i = 0; i < TABLE_ENTRIES; i++) task_claimed[i] = 1'b0;
    tasks_in_use = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg >= 0) begin
        in_valid <= 1'b0;
        set_in_use(dir_rows[i].cfg);
      end
      send_beat(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].x, dir_rows[i].y,
                dir_rows[i].taken, dir_rows[i].literal, dir_rows[i].lit_found,
                dir_rows[i].lit_idx);
    end

    // Fill the whole table so every later scan reads loaded coordinates.
    for (int i = 0; i < TABLE_ENTRIES; i++)
      send_beat(KIND_LOAD, i, rand_coord(), rand_coord(), 1'b0);

    // Writes to the unused slot must leave entries_in_use alone.
    in_valid <= 1'b0;
    set_in_use(2);
    cfg_write(UNUSED_ADDR, 32'd7);
    send_beat(KIND_QUERY, 0, 0, 0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (int s = 0; s < 4; s++) begin
        in_valid <= 1'b0;
        case (s)
          0: set_in_use(TABLE_ENTRIES);
          1: set_in_use((ph == 0) ? 511 : 1);
          2: set_in_use($urandom_range(TABLE_ENTRIES));
          default: set_in_use((ph == 3) ? 0 : $urandom_range(16));
        endcase
        if (ph == 0 && s == 0) hold_go = 1'b1;  // block fills, input stalls
        repeat (20) random_beat();
        // Refresh some claims so searches keep finding entries.
        repeat (10) send_beat(KIND_LOAD, $urandom_range(31), rand_coord(),
                              rand_coord(), 1'b0);
      end
    end
    in_valid <= 1'b0;

    wait (picks_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d loads and %0d queries (%0d found, %0d results checked),",
             n_loads, n_queries, n_found, n_checked);
    $display("table sizes from 0 to saturated, four idle/stall mixes, one long hold-off.");
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
